// File: hw/rtl/size_bounded_lru_table_core_defines.svh
// Assertion macros for the size-bounded LRU table core.
`ifndef SIZE_BOUNDED_LRU_TABLE_CORE_DEFINES_SVH
`define SIZE_BOUNDED_LRU_TABLE_CORE_DEFINES_SVH
// Check that an antecedent implies a consequent in the same cycle.
`define SBL_ASSERT_IMP(lbl, clk, rstn, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error(msg);
// Check that an antecedent implies a consequent in the next cycle.
`define SBL_ASSERT_NXT(lbl, clk, rstn, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error(msg);
`endif

// File: hw/rtl/sblt_pkg.sv
// Package with types, constants and mode codes of the size-bounded LRU table.
package sblt_pkg;
  localparam int unsigned ENTRIES_DEF   = 16;
  localparam int unsigned SIZE_BITS_DEF = 40;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned TOTAL_W = 9;

  localparam logic [2:0] MODE_INSERT = 3'd0;
  localparam logic [2:0] MODE_LOOKUP = 3'd1;
  localparam logic [2:0] MODE_PROBE  = 3'd2;
  localparam logic [2:0] MODE_REMOVE = 3'd3;
  localparam logic [2:0] MODE_FREE   = 3'd4;
  localparam logic [2:0] MODE_CLEAR  = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_MISS  = 2'd1;
  localparam logic [1:0] ST_LARGE = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SCAN_WAIT, S_DISPATCH, S_FIT, S_OLD, S_OLD_WAIT,
    S_EVICT, S_PLACE, S_OUT
  } state_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == '1) ? v : v + 1'b1;
  endfunction
endpackage

// File: hw/rtl/sblt_store.sv
// Slot store: key, size and stamp memories with registered read.
module sblt_store import sblt_pkg::*; #(
  parameter int unsigned ENTRIES   = ENTRIES_DEF,
  parameter int unsigned SIZE_BITS = SIZE_BITS_DEF,
  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                 clk,
  input  logic [IW-1:0]        rd_addr,
  output logic [KEY_W-1:0]     rd_key,
  output logic [SIZE_BITS-1:0] rd_size,
  output logic [STAMP_W-1:0]   rd_stamp,
  input  logic                 wr_en,
  input  logic                 wr_full,
  input  logic [IW-1:0]        wr_addr,
  input  logic [KEY_W-1:0]     wr_key,
  input  logic [SIZE_BITS-1:0] wr_size,
  input  logic [STAMP_W-1:0]   wr_stamp
);
  logic [KEY_W+SIZE_BITS-1:0] ks_mem [ENTRIES];
  logic [STAMP_W-1:0]         st_mem [ENTRIES];

  // Stamp is written on every write; key and size only on a full write.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      st_mem[wr_addr] <= wr_stamp;
      if (wr_full) ks_mem[wr_addr] <= {wr_key, wr_size};
    end
  end

  always_ff @(posedge clk) begin
    {rd_key, rd_size} <= ks_mem[rd_addr];
    rd_stamp          <= st_mem[rd_addr];
  end
endmodule

// File: hw/rtl/size_bounded_lru_table_core.sv
// Size-bounded LRU table core: top level with request sequencer and counters.
// A request scans all ENTRIES slots before it acts; each eviction rescans for the oldest
// stamp and yields one word. One request at a time: a new request is held off until the
// previous one is done and its last word has left; the single read port of the slot store,
// the number of evicted words and any output stall set the pace.
// Reset: synchronous active-low rst_n clears valid bits, counters, capacity and FSM.
`include "size_bounded_lru_table_core_defines.svh"
module size_bounded_lru_table_core import sblt_pkg::*; #(
  parameter int unsigned ENTRIES   = ENTRIES_DEF,
  parameter int unsigned SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [SIZE_BITS-1:0] cfg_capacity_bytes,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           in_mode,
  input  logic [KEY_W-1:0]     in_key,
  input  logic [SIZE_BITS-1:0] in_byte_count,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_status,
  output logic                 out_is_eviction,
  output logic [KEY_W-1:0]     out_out_key,
  output logic [SIZE_BITS-1:0] out_out_size,
  output logic                 out_last,
  output logic [SIZE_BITS-1:0] out_freed_bytes,
  output logic [SIZE_BITS-1:0] out_total_bytes,
  output logic [TOTAL_W-1:0]   out_entry_total,
  output logic [CNT_W-1:0]     out_hits,
  output logic [CNT_W-1:0]     out_misses,
  output logic [CNT_W-1:0]     out_evictions
);
  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);
  localparam logic [IW:0] LAST_IDX = (IW+1)'(ENTRIES - 1);

  state_t state_r, state_nxt;

  // Request word, held for the whole item.
  logic [2:0]           mode_r;
  logic [KEY_W-1:0]     key_r;
  logic [SIZE_BITS-1:0] bytes_r;

  // Architectural state.
  logic [ENTRIES-1:0]   valid_r;
  logic [SIZE_BITS-1:0] cap_r, used_r, freed_r;
  logic [CW-1:0]        count_r;
  logic [STAMP_W-1:0]   stamp_r;
  logic [CNT_W-1:0]     hits_r, misses_r, evict_r;

  // Scan bookkeeping: issue address, address of data returning, search results.
  logic [IW:0]          scan_r;
  logic [IW-1:0]        ret_r;
  logic                 ret_v_r;
  logic                 found_r;
  logic [IW-1:0]        fidx_r;
  logic [SIZE_BITS-1:0] fsize_r;
  logic                 best_v_r;
  logic [IW-1:0]        best_r;
  logic [STAMP_W-1:0]   best_age_r;
  logic [KEY_W-1:0]     bkey_r;
  logic [SIZE_BITS-1:0] bsize_r;

  // Output register.
  logic                 ov_r;
  logic [1:0]           o_status_r;
  logic                 o_ev_r, o_last_r;
  logic [KEY_W-1:0]     o_key_r;
  logic [SIZE_BITS-1:0] o_size_r, o_freed_r;

  logic [KEY_W-1:0]     rd_key;
  logic [SIZE_BITS-1:0] rd_size;
  logic [STAMP_W-1:0]   rd_stamp;
  logic                 wr_en, wr_full;
  logic [IW-1:0]        wr_addr, free_idx;
  logic                 free_any;

  sblt_store #(.ENTRIES(ENTRIES), .SIZE_BITS(SIZE_BITS)) u_store (
    .clk     (clk),
    .rd_addr (scan_r[IW-1:0]),
    .rd_key  (rd_key),
    .rd_size (rd_size),
    .rd_stamp(rd_stamp),
    .wr_en   (wr_en),
    .wr_full (wr_full),
    .wr_addr (wr_addr),
    .wr_key  (key_r),
    .wr_size (bytes_r),
    .wr_stamp(stamp_r)
  );

  // Lowest free slot, from the valid bits (priority encoder).
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_any = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  logic take_out, out_free, too_large, fit_ok, need_evict, scan_done, in_take, ov_set;
  logic [STAMP_W-1:0] age;
  assign take_out  = ov_r && !out_stall;
  assign out_free  = !ov_r || !out_stall;
  assign too_large = bytes_r > cap_r;
  assign fit_ok    = (used_r <= cap_r) && (bytes_r <= cap_r - used_r);
  assign need_evict = (mode_r == MODE_INSERT)
                      ? (!fit_ok || count_r == FULL_CNT) : !fit_ok;
  assign scan_done = (scan_r == LAST_IDX);
  assign age       = stamp_r - rd_stamp;
  // Load the output register when a word is due and the slot frees up.
  assign ov_set    = out_free && (state_r == S_EVICT || state_r == S_OUT);

  // Hold off a new request until the last word of the previous one has left,
  // so live totals and the output register stay put while a word waits.
  assign in_stall  = (state_r != S_IDLE) || ov_r;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = (state_r == S_IDLE);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:      if (in_take) state_nxt = S_SCAN;
      S_SCAN:      if (scan_done) state_nxt = S_SCAN_WAIT;
      S_SCAN_WAIT: state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        if ((mode_r == MODE_INSERT || mode_r == MODE_FREE) && !too_large)
          state_nxt = S_FIT;
        else
          state_nxt = S_OUT;
      end
      S_FIT: begin
        // Place only once a pending eviction word has left.
        if (need_evict && count_r != '0) state_nxt = S_OLD;
        else if (mode_r != MODE_INSERT) state_nxt = S_OUT;
        else if (out_free) state_nxt = S_PLACE;
      end
      S_OLD:       if (scan_done) state_nxt = S_OLD_WAIT;
      S_OLD_WAIT:  state_nxt = S_EVICT;
      S_EVICT:     if (out_free) state_nxt = S_FIT;
      S_PLACE:     state_nxt = S_OUT;
      S_OUT:       if (out_free) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // Store write strobes.
  always_comb begin
    wr_en   = 1'b0;
    wr_full = 1'b0;
    wr_addr = free_idx;
    if (state_r == S_PLACE && free_any) begin
      wr_en   = 1'b1;
      wr_full = 1'b1;
    end else if (state_r == S_DISPATCH && mode_r == MODE_LOOKUP && found_r) begin
      wr_en   = 1'b1;
      wr_addr = fidx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      valid_r  <= '0;
      cap_r    <= '0;
      used_r   <= '0;
      count_r  <= '0;
      stamp_r  <= '0;
      hits_r   <= '0;
      misses_r <= '0;
      evict_r  <= '0;
      ov_r     <= 1'b0;
      ret_v_r  <= 1'b0;
      scan_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (ov_set) ov_r <= 1'b1;
      else if (take_out) ov_r <= 1'b0;
      if (cfg_valid && cfg_ready) cap_r <= cfg_capacity_bytes;
      // Data returns in the cycle after its address is issued.
      ret_v_r <= (state_r == S_SCAN) || (state_r == S_OLD);
      ret_r   <= scan_r[IW-1:0];
      if (state_r == S_SCAN || state_r == S_OLD) begin
        if (!scan_done) scan_r <= scan_r + 1'b1;
      end else begin
        scan_r <= '0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_take) begin
            mode_r  <= in_mode;
            key_r   <= in_key;
            bytes_r <= in_byte_count;
            found_r <= 1'b0;
            freed_r <= '0;
          end
        end
        S_DISPATCH: begin
          o_status_r <= ST_OK;
          o_ev_r     <= 1'b0;
          o_last_r   <= 1'b1;
          o_key_r    <= key_r;
          o_size_r   <= '0;
          o_freed_r  <= '0;
          unique case (mode_r)
            MODE_INSERT: begin
              o_size_r <= bytes_r;
              if (too_large) o_status_r <= ST_LARGE;
              else if (found_r) begin
                // Replace: release the old entry without counting it.
                valid_r[fidx_r] <= 1'b0;
                count_r <= count_r - 1'b1;
                used_r  <= (used_r >= fsize_r) ? used_r - fsize_r : '0;
              end
            end
            MODE_LOOKUP: begin
              if (found_r) begin
                o_size_r <= fsize_r;
                hits_r   <= sat_inc(hits_r);
                stamp_r  <= stamp_r + 1'b1;
              end else begin
                o_status_r <= ST_MISS;
                misses_r   <= sat_inc(misses_r);
              end
            end
            MODE_PROBE: begin
              if (found_r) o_size_r <= fsize_r;
              else o_status_r <= ST_MISS;
            end
            MODE_REMOVE: begin
              if (found_r) begin
                o_size_r  <= fsize_r;
                o_freed_r <= fsize_r;
                valid_r[fidx_r] <= 1'b0;
                count_r <= count_r - 1'b1;
                used_r  <= (used_r >= fsize_r) ? used_r - fsize_r : '0;
                evict_r <= sat_inc(evict_r);
              end else begin
                o_status_r <= ST_MISS;
              end
            end
            MODE_FREE: begin
              if (too_large) o_status_r <= ST_LARGE;
            end
            MODE_CLEAR: begin
              valid_r <= '0;
              count_r <= '0;
              used_r  <= '0;
            end
            default: ;
          endcase
        end
        S_FIT: begin
          best_v_r <= 1'b0;
          o_freed_r <= freed_r;
        end
        S_EVICT: begin
          if (out_free) begin
            // Drop the victim and report it.
            valid_r[best_r] <= 1'b0;
            count_r <= count_r - 1'b1;
            used_r  <= (used_r >= bsize_r) ? used_r - bsize_r : '0;
            evict_r <= sat_inc(evict_r);
            freed_r <= freed_r + bsize_r;
            o_status_r <= ST_OK;
            o_ev_r     <= 1'b1;
            o_last_r   <= 1'b0;
            o_key_r    <= bkey_r;
            o_size_r   <= bsize_r;
            o_freed_r  <= freed_r + bsize_r;
          end
        end
        S_PLACE: begin
          if (free_any) begin
            valid_r[free_idx] <= 1'b1;
            count_r <= count_r + 1'b1;
            used_r  <= used_r + bytes_r;
            stamp_r <= stamp_r + 1'b1;
          end
          o_status_r <= ST_OK;
          o_ev_r     <= 1'b0;
          o_last_r   <= 1'b1;
          o_key_r    <= key_r;
          o_size_r   <= bytes_r;
          o_freed_r  <= freed_r;
        end
        S_OUT: begin
          if (out_free) begin
            if (mode_r == MODE_FREE && !too_large) begin
              o_status_r <= ST_OK;
              o_ev_r     <= 1'b0;
              o_last_r   <= 1'b1;
              o_key_r    <= key_r;
              o_size_r   <= '0;
            end
          end
        end
        default: ;
      endcase
      // Key search: first valid match.
      if (state_r == S_SCAN || state_r == S_SCAN_WAIT) begin
        if (ret_v_r && valid_r[ret_r] && rd_key == key_r && !found_r) begin
          found_r <= 1'b1;
          fidx_r  <= ret_r;
          fsize_r <= rd_size;
        end
      end
      // Oldest search: strictly larger age wins, so ties keep the lowest slot.
      if (state_r == S_OLD || state_r == S_OLD_WAIT) begin
        if (ret_v_r && valid_r[ret_r] && (!best_v_r || age > best_age_r)) begin
          best_v_r   <= 1'b1;
          best_r     <= ret_r;
          best_age_r <= age;
          bkey_r     <= rd_key;
          bsize_r    <= rd_size;
        end
      end
    end
  end

  assign out_valid       = ov_r;
  assign out_status      = o_status_r;
  assign out_is_eviction = o_ev_r;
  assign out_out_key     = o_key_r;
  assign out_out_size    = o_size_r;
  assign out_last        = o_last_r;
  assign out_freed_bytes = o_freed_r;
  assign out_total_bytes = used_r;
  assign out_entry_total = TOTAL_W'(count_r);
  assign out_hits        = hits_r;
  assign out_misses      = misses_r;
  assign out_evictions   = evict_r;

  `SBL_ASSERT_IMP(a_cnt_match, clk, rst_n, 1'b1,
                  count_r == CW'($countones(valid_r)), "entry count disagrees with valid bits")
  `SBL_ASSERT_IMP(a_evict_victim, clk, rst_n, state_r == S_EVICT,
                  best_v_r && valid_r[best_r], "eviction without a valid victim")
  `SBL_ASSERT_NXT(a_out_hold, clk, rst_n, ov_r && out_stall,
                  ov_r && $stable(o_key_r) && $stable(o_last_r), "stalled word changed")
  `SBL_ASSERT_IMP(a_idle_quiet, clk, rst_n, state_r == S_IDLE, !ov_r || o_last_r,
                  "partial result pending while idle")
endmodule

// File: dv/size_bounded_lru_table_checker.sv
`timescale 1ns / 1ps
// Result checker for the size-bounded LRU table: shadow table, expected words, compare.
module size_bounded_lru_table_checker import sblt_pkg::*; #(
  parameter int unsigned ENTRIES   = 16,
  parameter int unsigned SIZE_BITS = 40
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [SIZE_BITS-1:0] cfg_capacity_bytes,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [2:0]           in_mode,
  input  logic [KEY_W-1:0]     in_key,
  input  logic [SIZE_BITS-1:0] in_byte_count,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [1:0]           out_status,
  input  logic                 out_is_eviction,
  input  logic [KEY_W-1:0]     out_out_key,
  input  logic [SIZE_BITS-1:0] out_out_size,
  input  logic                 out_last,
  input  logic [SIZE_BITS-1:0] out_freed_bytes,
  input  logic [SIZE_BITS-1:0] out_total_bytes,
  input  logic [TOTAL_W-1:0]   out_entry_total,
  input  logic [CNT_W-1:0]     out_hits,
  input  logic [CNT_W-1:0]     out_misses,
  input  logic [CNT_W-1:0]     out_evictions,
  output int                   fail_count,
  output int                   pending_words
);
  typedef struct packed {
    logic [1:0]           status;
    logic                 evicted;
    logic [KEY_W-1:0]     key;
    logic [SIZE_BITS-1:0] size;
    logic                 last;
    logic [SIZE_BITS-1:0] freed;
    logic [SIZE_BITS-1:0] total;
    logic [TOTAL_W-1:0]   entries;
    logic [CNT_W-1:0]     hits;
    logic [CNT_W-1:0]     misses;
    logic [CNT_W-1:0]     evicts;
  } lru_word_t;

  lru_word_t            expected_words[$];
  logic [SIZE_BITS-1:0] cap;
  bit                   sh_valid[ENTRIES];
  logic [KEY_W-1:0]     sh_key[ENTRIES];
  logic [SIZE_BITS-1:0] sh_size[ENTRIES];
  logic [STAMP_W-1:0]   sh_stamp[ENTRIES];
  logic [STAMP_W-1:0]   stamp;
  logic [SIZE_BITS-1:0] used;
  logic [CNT_W-1:0]     hit_cnt, miss_cnt, evict_cnt;

  assign pending_words = expected_words.size();

  function automatic int live_count();
    int n;
    n = 0;
    for (int i = 0; i < ENTRIES; i++) if (sh_valid[i]) n++;
    return n;
  endfunction

  function automatic bit room_for(logic [SIZE_BITS-1:0] need);
    return used <= cap && need <= cap - used;
  endfunction

  function automatic void push_word(logic [1:0] st, logic ev, logic [KEY_W-1:0] k,
                                    logic [SIZE_BITS-1:0] sz, logic lst,
                                    logic [SIZE_BITS-1:0] fr);
    lru_word_t w;
    w = '{st, ev, k, sz, lst, fr, used, TOTAL_W'(live_count()), hit_cnt, miss_cnt,
          evict_cnt};
    expected_words = {expected_words, w};
  endfunction

  function automatic void drop_entry(int i);
    used = (used >= sh_size[i]) ? used - sh_size[i] : '0;
    sh_valid[i] = 0;
  endfunction

  // Evict least recently stamped entries until the need fits and, if a slot is wanted, one is free.
  function automatic logic [SIZE_BITS-1:0] evict_until(logic [SIZE_BITS-1:0] need,
                                                       bit want_slot);
    logic [SIZE_BITS-1:0] fr;
    logic [STAMP_W-1:0]   age, best_age;
    int                   best;
    fr = '0;
    while (!room_for(need) || (want_slot && live_count() == ENTRIES)) begin
      best = -1;
      best_age = '0;
      for (int i = 0; i < ENTRIES; i++) begin
        age = stamp - sh_stamp[i];
        if (sh_valid[i] && (best < 0 || age > best_age)) begin
          best = i;
          best_age = age;
        end
      end
      if (best < 0) break;
      drop_entry(best);
      evict_cnt = sat_inc(evict_cnt);
      fr = fr + sh_size[best];
      push_word(ST_OK, 1'b1, sh_key[best], sh_size[best], 1'b0, fr);
    end
    return fr;
  endfunction

  function automatic void predict_request(logic [2:0] md, logic [KEY_W-1:0] k,
                                          logic [SIZE_BITS-1:0] b);
    int                   hit_at;
    logic [SIZE_BITS-1:0] fr, s;
    hit_at = -1;
    for (int i = ENTRIES - 1; i >= 0; i--) if (sh_valid[i] && sh_key[i] == k) hit_at = i;
    case (md)
      MODE_INSERT: begin
        if (b > cap) begin
          push_word(ST_LARGE, 1'b0, k, b, 1'b1, '0);
        end else begin
          if (hit_at >= 0) drop_entry(hit_at);
          fr = evict_until(b, 1'b1);
          for (int i = 0; i < ENTRIES; i++) begin
            if (!sh_valid[i]) begin
              sh_valid[i] = 1;
              sh_key[i] = k;
              sh_size[i] = b;
              sh_stamp[i] = stamp;
              stamp = stamp + 1'b1;
              used = used + b;
              break;
            end
          end
          push_word(ST_OK, 1'b0, k, b, 1'b1, fr);
        end
      end
      MODE_LOOKUP: begin
        if (hit_at >= 0) begin
          sh_stamp[hit_at] = stamp;
          stamp = stamp + 1'b1;
          hit_cnt = sat_inc(hit_cnt);
          push_word(ST_OK, 1'b0, k, sh_size[hit_at], 1'b1, '0);
        end else begin
          miss_cnt = sat_inc(miss_cnt);
          push_word(ST_MISS, 1'b0, k, '0, 1'b1, '0);
        end
      end
      MODE_PROBE: begin
        if (hit_at >= 0) push_word(ST_OK, 1'b0, k, sh_size[hit_at], 1'b1, '0);
        else push_word(ST_MISS, 1'b0, k, '0, 1'b1, '0);
      end
      MODE_REMOVE: begin
        if (hit_at >= 0) begin
          s = sh_size[hit_at];
          drop_entry(hit_at);
          evict_cnt = sat_inc(evict_cnt);
          push_word(ST_OK, 1'b0, k, s, 1'b1, s);
        end else begin
          push_word(ST_MISS, 1'b0, k, '0, 1'b1, '0);
        end
      end
      MODE_FREE: begin
        if (b > cap) begin
          push_word(ST_LARGE, 1'b0, k, '0, 1'b1, '0);
        end else begin
          fr = evict_until(b, 1'b0);
          push_word(ST_OK, 1'b0, k, '0, 1'b1, fr);
        end
      end
      MODE_CLEAR: begin
        for (int i = 0; i < ENTRIES; i++) sh_valid[i] = 0;
        used = '0;
        push_word(ST_OK, 1'b0, k, '0, 1'b1, '0);
      end
      default: push_word(ST_OK, 1'b0, k, '0, 1'b1, '0);
    endcase
  endfunction

  always @(posedge clk) begin
    lru_word_t got, want;
    if (!rst_n) begin
      cap <= '0;
      stamp <= '0;
      used <= '0;
      hit_cnt <= '0;
      miss_cnt <= '0;
      evict_cnt <= '0;
      fail_count <= 0;
      for (int i = 0; i < ENTRIES; i++) sh_valid[i] = 0;
      expected_words.delete();
    end else begin
      // Score the output word first; an input word cannot cause a same-edge result.
      if (out_valid && !out_stall) begin
        got = '{out_status, out_is_eviction, out_out_key, out_out_size, out_last,
                out_freed_bytes, out_total_bytes, out_entry_total, out_hits,
                out_misses, out_evictions};
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word, actual %p", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) cap = cfg_capacity_bytes;
      if (in_valid && !in_stall) predict_request(in_mode, in_key, in_byte_count);
    end
  end

  initial fail_count = 0;
endmodule

// File: dv/size_bounded_lru_table_core_tb.sv
`timescale 1ns / 1ps
// Top of the size-bounded LRU table testbench: clock, reset, stimulus, verdict.
module size_bounded_lru_table_core_tb import sblt_pkg::*;;
  localparam int unsigned ENTRIES   = 16;
  localparam int unsigned SIZE_BITS = 40;
  localparam int unsigned DRAIN_CYCLES = 4 * ENTRIES + 20;
  localparam longint CYCLE_LIMIT = 900000;

  logic                 clk = 0;
  logic                 rst_n = 0;
  logic                 cfg_valid = 0;
  logic                 cfg_ready;
  logic [SIZE_BITS-1:0] cfg_capacity_bytes = '0;
  logic                 in_valid = 0;
  logic                 in_stall;
  logic [2:0]           in_mode = '0;
  logic [KEY_W-1:0]     in_key = '0;
  logic [SIZE_BITS-1:0] in_byte_count = '0;
  logic                 out_valid;
  logic                 out_stall = 1;
  logic [1:0]           out_status;
  logic                 out_is_eviction;
  logic [KEY_W-1:0]     out_out_key;
  logic [SIZE_BITS-1:0] out_out_size;
  logic                 out_last;
  logic [SIZE_BITS-1:0] out_freed_bytes;
  logic [SIZE_BITS-1:0] out_total_bytes;
  logic [TOTAL_W-1:0]   out_entry_total;
  logic [CNT_W-1:0]     out_hits, out_misses, out_evictions;
  int                   fail_count, pending_words;
  longint               cycle_count = 0;
  bit                   hold_off = 0;   // long receiver stall requested by stimulus
  bit                   no_gaps = 0;    // stretch with no idling on either side
  logic [KEY_W-1:0]     key_pool[8];

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  size_bounded_lru_table_core #(.ENTRIES(ENTRIES), .SIZE_BITS(SIZE_BITS)) u_dut (.*);

  size_bounded_lru_table_checker #(.ENTRIES(ENTRIES), .SIZE_BITS(SIZE_BITS)) u_chk (.*);

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: draw a stall length per word, honor long hold-offs.
  initial begin
    int gap;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off) begin
        out_stall <= 1;
        repeat (600) @(posedge clk);
        hold_off = 0;
      end
      gap = no_gaps ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
        out_stall <= 1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 0;
      @(posedge clk iff out_valid);
    end
  end

  // Offer one request word and hold it until accepted; valid stays up into
  // the next call, which either drops it for a gap or offers the next word.
  task automatic send_request(logic [2:0] md, logic [KEY_W-1:0] k,
                              logic [SIZE_BITS-1:0] b);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_mode <= md;
    in_key <= k;
    in_byte_count <= b;
    @(posedge clk iff !in_stall);
  endtask

  // Drain all expected words, settle, then write the capacity.
  task automatic set_capacity(logic [SIZE_BITS-1:0] c);
    in_valid <= 0;
    @(posedge clk iff pending_words == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1;
    cfg_capacity_bytes <= c;
    @(posedge clk iff cfg_ready);
    cfg_valid <= 0;
  endtask

  // Mostly pooled keys so hits, replacements and evictions are common.
  function automatic logic [KEY_W-1:0] pick_key();
    return ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, 7)] : $urandom;
  endfunction

  function automatic logic [SIZE_BITS-1:0] pick_size(logic [SIZE_BITS-1:0] c);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return c;
      2: return SIZE_BITS'({$urandom, $urandom});
      default: return (c == 0) ? '0 : SIZE_BITS'({$urandom, $urandom} % (64'(c) / 4 + 1));
    endcase
  endfunction

  task automatic random_phase(int n, logic [SIZE_BITS-1:0] c);
    logic [2:0] md;
    for (int i = 0; i < n; i++) begin
      md = ($urandom_range(0, 9) < 4) ? MODE_INSERT : 3'($urandom_range(0, 7));
      if (md == MODE_CLEAR && $urandom_range(0, 3) != 0) md = MODE_LOOKUP;
      send_request(md, pick_key(), pick_size(c));
    end
  endtask

  initial begin
    logic [SIZE_BITS-1:0] caps[6];
    for (int i = 0; i < 8; i++) key_pool[i] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = '1;
    caps = '{40'd1000, 40'd0, {SIZE_BITS{1'b1}}, 40'd300, 40'd50000, 40'd5000};
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: empty table, extremes, every mode, too large, replacement, full table.
    set_capacity(40'd1000);
    send_request(MODE_LOOKUP, '0, '0);
    send_request(MODE_INSERT, '0, '0);
    send_request(MODE_INSERT, '1, 40'd1000);
    send_request(MODE_INSERT, 32'h5, 40'd1001);
    send_request(MODE_FREE, 32'h6, {SIZE_BITS{1'b1}});
    send_request(MODE_INSERT, 32'h7, 40'd400);
    send_request(MODE_INSERT, 32'h8, 40'd300);
    send_request(MODE_LOOKUP, 32'h7, '0);
    send_request(MODE_INSERT, 32'h8, 40'd500);
    send_request(MODE_PROBE, 32'h8, '0);
    send_request(MODE_PROBE, 32'h9, '0);
    send_request(MODE_REMOVE, 32'h7, '0);
    send_request(MODE_REMOVE, 32'h7, '0);
    send_request(MODE_FREE, 32'h0, 40'd900);
    send_request(3'd6, 32'hA5A5A5A5, 40'd1);
    send_request(3'd7, 32'h5A5A5A5A, 40'd2);
    for (int i = 0; i < 18; i++) send_request(MODE_INSERT, 32'h100 + i, 40'd1);
    send_request(MODE_CLEAR, 32'h3, '0);

    // Lower capacity under a loaded table; the next insert must evict.
    for (int i = 0; i < 4; i++) send_request(MODE_INSERT, 32'h200 + i, 40'd200);
    set_capacity(40'd250);
    send_request(MODE_INSERT, 32'h300, 40'd10);

    // Long receiver hold-off while requests keep coming.
    hold_off = 1;
    random_phase(20, 40'd250);

    foreach (caps[p]) begin
      set_capacity(caps[p]);
      no_gaps = (p == 3);
      random_phase(52, caps[p]);
    end
    no_gaps = 0;

    in_valid <= 0;
    @(posedge clk iff pending_words == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_words == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// File: size_bounded_lru_table_core.f
+incdir+hw/rtl
hw/rtl/sblt_pkg.sv
hw/rtl/sblt_store.sv
hw/rtl/size_bounded_lru_table_core.sv
dv/size_bounded_lru_table_checker.sv
dv/size_bounded_lru_table_core_tb.sv
